// ----- design/ajat_pkg.sv -----
// Package for the arm joint angle block: widths, the CORDIC angle table and
// the shared pipeline vector type. No dependencies.
package ajat_pkg;

	localparam int ANGLE_ITERATIONS = 16;
	localparam int TABLE_LEN        = 24;
	localparam int ITERS = (ANGLE_ITERATIONS > TABLE_LEN) ? TABLE_LEN : ANGLE_ITERATIONS;

	localparam int PW          = 13;                   // input position width
	localparam int DW          = PW + 1;               // difference width
	localparam int GUARD_SHIFT = 24;
	localparam int CW          = DW + GUARD_SHIFT + 3; // vector component width
	localparam int ZW          = 25;                   // angle accumulator, 2^-16 deg
	localparam int SW          = ZW + 2;               // angle sum width
	localparam int OW          = 14;                   // result width, 1/16 deg
	localparam int FRAC_SHIFT  = 12;

	localparam int DEG90 = 90 * 65536;
	localparam int RND   = 1 << (FRAC_SHIFT - 1);

	// atan(2^-i) in degrees times 65536
	localparam int ROT_TABLE [TABLE_LEN] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 zero;
	} vec_t;

endpackage

// ----- design/arm_joint_angles_atan2.sv -----
// Arm joint angles: shoulder and elbow servo angles in 1/16 degree from the
// shoulder, elbow and hand positions. One item enters per clock while the
// output is not blocked. Stages in order: difference, quadrant, one per CORDIC
// micro-rotation, rounding. The whole pipeline advances together and holds
// while the output is valid and not taken.
// Uses ajat_pkg and ajat_cordic.
module arm_joint_angles_atan2 (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [ajat_pkg::PW-1:0]    shoulder_x,
	input  logic signed [ajat_pkg::PW-1:0]    shoulder_y,
	input  logic signed [ajat_pkg::PW-1:0]    elbow_x,
	input  logic signed [ajat_pkg::PW-1:0]    elbow_y,
	input  logic signed [ajat_pkg::PW-1:0]    hand_x,
	input  logic signed [ajat_pkg::PW-1:0]    hand_y,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [ajat_pkg::OW-1:0]    shoulder_angle,
	output logic signed [ajat_pkg::OW-1:0]    elbow_angle
);
	import ajat_pkg::*;

	localparam int NV = ITERS + 3;

	logic                 en;
	logic                 vld_s [NV];
	logic signed [DW-1:0] dxs_s1, dys_s1, dxe_s1, dye_s1;
	logic signed [ZW-1:0] a_sh, a_fa;
	logic signed [SW-1:0] sum_sh, sum_el;
	logic signed [OW-1:0] sh_res_sout, el_res_sout;

	assign en       = !vld_s[NV-1] || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NV; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k < NV; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dxs_s1 <= DW'(elbow_x) - DW'(shoulder_x);
			dys_s1 <= DW'(shoulder_y) - DW'(elbow_y);
			dxe_s1 <= DW'(hand_x) - DW'(elbow_x);
			dye_s1 <= DW'(hand_y) - DW'(elbow_y);
		end
	end

	ajat_cordic u_cordic_sh (
		.clk   (clk),
		.en    (en),
		.dx    (dxs_s1),
		.dy    (dys_s1),
		.angle (a_sh)
	);

	ajat_cordic u_cordic_fa (
		.clk   (clk),
		.en    (en),
		.dx    (dxe_s1),
		.dy    (dye_s1),
		.angle (a_fa)
	);

	assign sum_sh = SW'(a_sh) + SW'(DEG90) + SW'(RND);
	assign sum_el = SW'(a_sh) + SW'(a_fa) + SW'(RND);

	always_ff @(posedge clk) begin
		if (en) begin
			sh_res_sout <= sum_sh[FRAC_SHIFT +: OW];
			el_res_sout <= sum_el[FRAC_SHIFT +: OW];
		end
	end

	assign out_valid      = vld_s[NV-1];
	assign shoulder_angle = sh_res_sout;
	assign elbow_angle    = el_res_sout;

	a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without a blocked output");

	a_shoulder_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (shoulder_angle >= -14'sd1440 && shoulder_angle <= 14'sd4320))
		else $error("shoulder angle out of range");

	a_elbow_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (elbow_angle >= -14'sd5760 && elbow_angle <= 14'sd5760))
		else $error("elbow angle out of range");

endmodule

// ----- design/ajat_cordic.sv -----
// Vectoring CORDIC pipeline: quadrant pre-rotation stage, then one register
// stage per micro-rotation. Uses ajat_pkg. Valid bits are kept by the caller.
module ajat_cordic (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [ajat_pkg::DW-1:0]    dx,
	input  logic signed [ajat_pkg::DW-1:0]    dy,
	output logic signed [ajat_pkg::ZW-1:0]    angle
);
	import ajat_pkg::*;

	vec_t vec_s [ITERS+1];
	vec_t pre;
	vec_t nxt [ITERS];

	always_comb begin
		pre.zero = (dx == '0) && (dy == '0);
		if (dx < 0) begin
			if (dy >= 0) begin
				pre.x = CW'(dy) <<< GUARD_SHIFT;
				pre.y = (-CW'(dx)) <<< GUARD_SHIFT;
				pre.z = ZW'(DEG90);
			end else begin
				pre.x = (-CW'(dy)) <<< GUARD_SHIFT;
				pre.y = CW'(dx) <<< GUARD_SHIFT;
				pre.z = -ZW'(DEG90);
			end
		end else begin
			pre.x = CW'(dx) <<< GUARD_SHIFT;
			pre.y = CW'(dy) <<< GUARD_SHIFT;
			pre.z = '0;
		end
	end

	always_comb begin
		for (int k = 0; k < ITERS; k++) begin
			nxt[k].zero = vec_s[k].zero;
			if (vec_s[k].y >= 0) begin
				nxt[k].x = vec_s[k].x + (vec_s[k].y >>> k);
				nxt[k].y = vec_s[k].y - (vec_s[k].x >>> k);
				nxt[k].z = vec_s[k].z + ZW'(ROT_TABLE[k]);
			end else begin
				nxt[k].x = vec_s[k].x - (vec_s[k].y >>> k);
				nxt[k].y = vec_s[k].y + (vec_s[k].x >>> k);
				nxt[k].z = vec_s[k].z - ZW'(ROT_TABLE[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s[0] <= pre;
			for (int k = 0; k < ITERS; k++) begin
				vec_s[k+1] <= nxt[k];
			end
		end
	end

	assign angle = vec_s[ITERS].zero ? '0 : vec_s[ITERS].z;

endmodule

// ----- tb/arm_joint_angles_atan2_test.sv -----
// Self-checking testbench for arm_joint_angles_atan2: drives shoulder/elbow/hand
// poses, predicts both servo angles with a bit-exact vectoring CORDIC model.
// Depends on ajat_pkg and the arm_joint_angles_atan2 RTL.
`timescale 1ns / 100ps

module arm_joint_angles_atan2_test;
	import ajat_pkg::*;

	localparam int     N_RANDOM    = 400;
	localparam int     LIMIT       = 200000;
	localparam int     HOLD_CYCLES = 80;
	localparam int     HOLD_AT     = 260;
	localparam int     QUIET_LO    = 120;
	localparam int     QUIET_HI    = 200;
	localparam int     MAX_REPORTS = 10;
	localparam int     STEP_LIMIT  = 24;
	localparam longint QUARTER     = 90 * 65536;
	localparam int     HALF_LSB    = 2048;

	// atan(2^-i) in 2^-16 degree
	localparam int MICRO_ROT [STEP_LIMIT] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	typedef struct {
		logic signed [PW-1:0] sx, sy, ex, ey, hx, hy;
	} pose_t;

	typedef struct {
		logic signed [OW-1:0] shoulder;
		logic signed [OW-1:0] elbow;
	} angles_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic signed [PW-1:0] shoulder_x = '0;
	logic signed [PW-1:0] shoulder_y = '0;
	logic signed [PW-1:0] elbow_x = '0;
	logic signed [PW-1:0] elbow_y = '0;
	logic signed [PW-1:0] hand_x = '0;
	logic signed [PW-1:0] hand_y = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic signed [OW-1:0] shoulder_angle;
	logic signed [OW-1:0] elbow_angle;

	pose_t   pose_queue[$];
	angles_t angle_due[$];

	int cycles;
	int accepted;
	int issued;
	int checked;
	int errors;
	int stall_cycles;
	int n_directed;
	int hold_left;
	bit hold_done;

	arm_joint_angles_atan2 dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.shoulder_x(shoulder_x),
		.shoulder_y(shoulder_y),
		.elbow_x(elbow_x),
		.elbow_y(elbow_y),
		.hand_x(hand_x),
		.hand_y(hand_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.shoulder_angle(shoulder_angle),
		.elbow_angle(elbow_angle)
	);

	// atan2(vy, vx) in 2^-16 degree
	function automatic longint heading(longint vy, longint vx);
		longint x, y, z, t, xs, ys;
		int     n;
		if (vx == 0 && vy == 0)
			return 0;
		x = vx <<< GUARD_SHIFT;
		y = vy <<< GUARD_SHIFT;
		z = 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = QUARTER;
			end else begin
				t = x; x = -y; y = t; z = -QUARTER;
			end
		end
		n = (ANGLE_ITERATIONS > STEP_LIMIT) ? STEP_LIMIT : ANGLE_ITERATIONS;
		for (int i = 0; i < n; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys; y = y - xs; z = z + MICRO_ROT[i];
			end else begin
				x = x - ys; y = y + xs; z = z - MICRO_ROT[i];
			end
		end
		return z;
	endfunction

	function automatic angles_t joint_angles(pose_t p);
		longint  a_upper, a_fore, sh, el;
		angles_t r;
		a_upper = heading(-(longint'(p.ey) - longint'(p.sy)), longint'(p.ex) - longint'(p.sx));
		a_fore  = heading(longint'(p.hy) - longint'(p.ey), longint'(p.hx) - longint'(p.ex));
		sh = (a_upper + QUARTER + HALF_LSB) >>> FRAC_SHIFT;
		el = (a_fore + a_upper + HALF_LSB) >>> FRAC_SHIFT;
		r.shoulder = sh[OW-1:0];
		r.elbow    = el[OW-1:0];
		return r;
	endfunction

	function automatic int fit13(int v);
		if (v > 4095)
			return 4095;
		if (v < -4096)
			return -4096;
		return v;
	endfunction

	function automatic int rnd(int lo, int hi);
		return lo + int'($urandom_range(hi - lo));
	endfunction

	function automatic pose_t mk_pose(int sx, int sy, int ex, int ey, int hx, int hy);
		pose_t p;
		p.sx = sx[PW-1:0]; p.sy = sy[PW-1:0];
		p.ex = ex[PW-1:0]; p.ey = ey[PW-1:0];
		p.hx = hx[PW-1:0]; p.hy = hy[PW-1:0];
		return p;
	endfunction

	function automatic pose_t random_pose();
		int kind, sx, sy, ex, ey, hx, hy;
		kind = $urandom_range(99);
		if (kind < 40) begin
			sx = rnd(-1500, 1500); sy = rnd(-1500, 1500);
			ex = fit13(sx + rnd(-400, 400)); ey = fit13(sy + rnd(-400, 400));
			hx = fit13(ex + rnd(-400, 400)); hy = fit13(ey + rnd(-400, 400));
		end else if (kind < 85) begin
			sx = rnd(-4096, 4095); sy = rnd(-4096, 4095);
			ex = rnd(-4096, 4095); ey = rnd(-4096, 4095);
			hx = rnd(-4096, 4095); hy = rnd(-4096, 4095);
		end else begin
			sx = rnd(-4096, 4095); sy = rnd(-4096, 4095);
			ex = rnd(-4096, 4095); ey = rnd(-4096, 4095);
			hx = rnd(-4096, 4095); hy = rnd(-4096, 4095);
			case ($urandom_range(3))
				0: begin ex = sx; ey = sy; end
				1: begin hx = ex; hy = ey; end
				2: begin hy = ey; hx = fit13(ex - rnd(1, 4000)); end
				default: begin ey = sy; ex = fit13(sx - rnd(1, 4000)); end
			endcase
		end
		return mk_pose(sx, sy, ex, ey, hx, hy);
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// sender: new pose only once the previous one has transferred
	always @(negedge clk) begin : driver
		pose_t p;
		bit    quiet;
		if (arst_n && (!in_valid || accepted == issued)) begin
			quiet = accepted >= QUIET_LO && accepted < QUIET_HI;
			if (pose_queue.size() != 0 && (quiet || $urandom_range(99) >= 33)) begin
				p = pose_queue.pop_front();
				shoulder_x <= p.sx; shoulder_y <= p.sy;
				elbow_x    <= p.ex; elbow_y    <= p.ey;
				hand_x     <= p.hx; hand_y     <= p.hy;
				in_valid   <= 1'b1;
				issued     = issued + 1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, one long hold-off to back up the pipeline
	always @(negedge clk) begin : receiver
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				out_ready <= 1'b0;
			end else if (!hold_done && accepted >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				out_ready <= 1'b0;
			end else if (accepted >= QUIET_LO && accepted < QUIET_HI) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 33);
			end
		end
	end

	always @(posedge clk) begin : monitor
		pose_t   p;
		angles_t got, want;
		if (arst_n) begin
			cycles = cycles + 1;
			if (in_valid && !in_ready)
				stall_cycles = stall_cycles + 1;
			if (in_valid && in_ready) begin
				p.sx = shoulder_x; p.sy = shoulder_y;
				p.ex = elbow_x;    p.ey = elbow_y;
				p.hx = hand_x;     p.hy = hand_y;
				angle_due.push_back(joint_angles(p));
				accepted = accepted + 1;
			end
			if (out_valid && out_ready) begin
				got.shoulder = shoulder_angle;
				got.elbow    = elbow_angle;
				if (angle_due.size() == 0) begin
					if (errors < MAX_REPORTS)
						$display("%0t: unexpected transfer, shoulder_angle %0d elbow_angle %0d",
							$realtime, got.shoulder, got.elbow);
					errors = errors + 1;
				end else begin
					want = angle_due.pop_front();
					checked = checked + 1;
					if (got.shoulder !== want.shoulder || got.elbow !== want.elbow) begin
						if (errors < MAX_REPORTS)
							$display("%0t: result %0d: shoulder_angle exp %0d got %0d, elbow_angle exp %0d got %0d",
								$realtime, checked, want.shoulder, got.shoulder,
								want.elbow, got.elbow);
						errors = errors + 1;
					end
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;

		// zero vectors, negative x axis, corners, axes, unit steps
		pose_queue.push_back(mk_pose(0, 0, 0, 0, 0, 0));
		pose_queue.push_back(mk_pose(0, 0, 0, 0, -100, 0));
		pose_queue.push_back(mk_pose(50, 0, -50, 0, -50, 0));
		pose_queue.push_back(mk_pose(4095, 7, -4096, 7, -4096, -1));
		pose_queue.push_back(mk_pose(4095, 0, -4096, -1, 4095, 0));
		pose_queue.push_back(mk_pose(-4096, -4096, 4095, 4095, -4096, -4096));
		pose_queue.push_back(mk_pose(4095, 4095, -4096, -4096, 4095, 4095));
		pose_queue.push_back(mk_pose(4095, -4096, -4096, 4095, 4095, -4096));
		pose_queue.push_back(mk_pose(-4096, 4095, 4095, -4096, -4096, 4095));
		pose_queue.push_back(mk_pose(4095, 4095, 4095, 4095, 4095, 4095));
		pose_queue.push_back(mk_pose(-4096, -4096, -4096, -4096, -4096, -4096));
		pose_queue.push_back(mk_pose(0, 0, 100, 0, 200, 0));
		pose_queue.push_back(mk_pose(0, 0, 0, -100, 0, 0));
		pose_queue.push_back(mk_pose(0, 0, 0, 100, 0, 300));
		pose_queue.push_back(mk_pose(0, 0, 0, 4095, 0, -4096));
		pose_queue.push_back(mk_pose(0, 0, 1, 0, 1, 1));
		pose_queue.push_back(mk_pose(0, 0, -1, 1, -2, 0));
		pose_queue.push_back(mk_pose(0, 0, -1, -1, -2, -2));
		pose_queue.push_back(mk_pose(0, 0, -4096, 1, 4095, 1));
		pose_queue.push_back(mk_pose(4095, -4096, -4096, -4095, 4095, -4095));
		pose_queue.push_back(mk_pose(0, 0, 300, -300, 300, 0));
		pose_queue.push_back(mk_pose(-1000, 500, -1000, 500, -1000, 500));
		n_directed = pose_queue.size();
		repeat (N_RANDOM)
			pose_queue.push_back(random_pose());

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (!(pose_queue.size() == 0 && !in_valid && angle_due.size() == 0)
				&& cycles < LIMIT)
			@(negedge clk);
		if (cycles < LIMIT)
			repeat (ITERS + 13) @(negedge clk);

		if (cycles >= LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, angle_due.size());
			$display("end of test: mismatches");
		end else begin
			$display("covered %0d poses (%0d directed), %0d angle pairs checked, %0d errors",
				accepted, n_directed, checked, errors);
			$display("input held off %0d cycles, including one %0d-cycle output stall",
				stall_cycles, HOLD_CYCLES);
			if (errors == 0 && angle_due.size() == 0)
				$display("end of test: clean");
			else
				$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
